[rtl/mts_pkg.sv]
// Shared types and register index codes for the midtone transfer stretch unit.
// No dependencies.
package mts_pkg;

    // Configuration register index
    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MONO      = 3'd0;
    localparam t_cfg_idx CFG_CLIP_RED  = 3'd1;
    localparam t_cfg_idx CFG_CLIP_GRN  = 3'd2;
    localparam t_cfg_idx CFG_CLIP_BLU  = 3'd3;
    localparam t_cfg_idx CFG_BAL_RED   = 3'd4;
    localparam t_cfg_idx CFG_BAL_GRN   = 3'd5;
    localparam t_cfg_idx CFG_BAL_BLU   = 3'd6;

endpackage

[rtl/mts_cfg.sv]
// Configuration register file for the stretch unit.
// Depends on mts_pkg for the register index codes.
module mts_cfg
    import mts_pkg::*;
#(
    parameter int F = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  t_cfg_idx       i_index,
    input  logic [F:0]     i_data,
    output logic           o_mono,
    output logic [F:0]     o_clip_red,
    output logic [F:0]     o_clip_green,
    output logic [F:0]     o_clip_blue,
    output logic [F-1:0]   o_bal_red,
    output logic [F-1:0]   o_bal_green,
    output logic [F-1:0]   o_bal_blue
);

    localparam logic [F-1:0] BAL_RESET = F'(1) << (F - 1);

    logic         r_mono;
    logic [F:0]   r_clip_r, r_clip_g, r_clip_b;
    logic [F-1:0] r_bal_r, r_bal_g, r_bal_b;

    // register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono   <= 1'b0;
            r_clip_r <= '0;
            r_clip_g <= '0;
            r_clip_b <= '0;
            r_bal_r  <= BAL_RESET;
            r_bal_g  <= BAL_RESET;
            r_bal_b  <= BAL_RESET;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_MONO:     r_mono   <= i_data[0];
                CFG_CLIP_RED: r_clip_r <= i_data;
                CFG_CLIP_GRN: r_clip_g <= i_data;
                CFG_CLIP_BLU: r_clip_b <= i_data;
                CFG_BAL_RED:  r_bal_r  <= i_data[F-1:0];
                CFG_BAL_GRN:  r_bal_g  <= i_data[F-1:0];
                CFG_BAL_BLU:  r_bal_b  <= i_data[F-1:0];
                default: ;
            endcase
        end
    end

    assign o_mono       = r_mono;
    assign o_clip_red   = r_clip_r;
    assign o_clip_green = r_clip_g;
    assign o_clip_blue  = r_clip_b;
    assign o_bal_red    = r_bal_r;
    assign o_bal_green  = r_bal_g;
    assign o_bal_blue   = r_bal_b;

endmodule

[rtl/mts_chan.sv]
// One color channel: clip rescale and midtone transfer map, fully pipelined.
// Two restoring dividers of one quotient bit per stage. Uses mts_pkg.
module mts_chan
    import mts_pkg::*;
#(
    parameter int F = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [F:0]     i_p,
    input  logic [F:0]     i_clip,
    input  logic [F-1:0]   i_bal,
    output logic [F:0]     o_y
);

    localparam logic [F:0] ONE = (F+1)'(1) << F;
    localparam int         W2  = 2*F + 2;

    // rescale divider stages, index 0 is the entry stage
    logic [F:0]   r_rem1 [0:F];
    logic [F:0]   r_den1 [0:F];
    logic [F-1:0] r_q1   [0:F];
    logic [F-1:0] r_b1   [0:F];
    logic         r_z1   [0:F];
    logic         r_s1   [0:F];

    // entry: clip test, difference, saturation test
    logic [F:0] diff, den;
    logic       zero;
    assign diff = i_p - i_clip;
    assign den  = ONE - i_clip;
    assign zero = (i_clip >= ONE) || (i_p <= i_clip);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem1[0] <= diff;
            r_den1[0] <= den;
            r_q1[0]   <= '0;
            r_b1[0]   <= i_bal;
            r_z1[0]   <= zero;
            r_s1[0]   <= !zero && (diff >= den);
        end
    end

    for (genvar k = 1; k <= F; k++) begin : g_div1
        logic [F+1:0] t;
        logic         ge;
        logic [F+1:0] sub;
        assign t   = {r_rem1[k-1], 1'b0};
        assign ge  = t >= {1'b0, r_den1[k-1]};
        assign sub = t - {1'b0, r_den1[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem1[k] <= ge ? sub[F:0] : t[F:0];
                r_den1[k] <= r_den1[k-1];
                r_q1[k]   <= {r_q1[k-1][F-2:0], ge};
                r_b1[k]   <= r_b1[k-1];
                r_z1[k]   <= r_z1[k-1];
                r_s1[k]   <= r_s1[k-1];
            end
        end
    end

    // products (ONE-b)*x and b*(ONE-x)
    logic [F-1:0]   x;
    logic [F:0]     omb, omx;
    logic [2*F+1:0] pn, pm;
    logic [2*F:0]   r_n, r_m;
    logic           r_zm, r_sm;
    assign x   = r_q1[F];
    assign omb = ONE - {1'b0, r_b1[F]};
    assign omx = ONE - {1'b0, x};
    assign pn  = (2*F+2)'(omb) * (2*F+2)'(x);
    assign pm  = (2*F+2)'(r_b1[F]) * (2*F+2)'(omx);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n  <= pn[2*F:0];
            r_m  <= pm[2*F:0];
            r_zm <= r_z1[F] || (x == '0);
            r_sm <= r_s1[F];
        end
    end

    // map divider stages, index 0 holds numerator and denominator
    logic [W2-1:0] r_rem2 [0:F];
    logic [W2-1:0] r_den2 [0:F];
    logic [F-1:0]  r_q2   [0:F];
    logic          r_z2   [0:F];
    logic          r_s2   [0:F];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem2[0] <= W2'(r_n);
            r_den2[0] <= W2'(r_n) + W2'(r_m);
            r_q2[0]   <= '0;
            r_z2[0]   <= r_zm;
            // zero balance: quotient is exactly one
            r_s2[0]   <= r_sm || (r_m == '0);
        end
    end

    for (genvar k = 1; k <= F; k++) begin : g_div2
        logic [W2:0] t;
        logic        ge;
        logic [W2:0] sub;
        assign t   = {r_rem2[k-1], 1'b0};
        assign ge  = t >= {1'b0, r_den2[k-1]};
        assign sub = t - {1'b0, r_den2[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem2[k] <= ge ? sub[W2-1:0] : t[W2-1:0];
                r_den2[k] <= r_den2[k-1];
                r_q2[k]   <= {r_q2[k-1][F-2:0], ge};
                r_z2[k]   <= r_z2[k-1];
                r_s2[k]   <= r_s2[k-1];
            end
        end
    end

    // output select
    logic [F:0] r_y;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_z2[F])      r_y <= '0;
            else if (r_s2[F]) r_y <= ONE;
            else              r_y <= {1'b0, r_q2[F]};
        end
    end

    assign o_y = r_y;

endmodule

[rtl/midtone_transfer_stretch_unit.sv]
// Midtone transfer stretch unit, top level.
// Depends on mts_pkg, mts_cfg and mts_chan.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one RGB pixel word
//   (Q1.F samples). Output channel: o_out_valid / i_out_stall carry the
//   stretched word. A word moves on a clock edge with valid high and stall
//   low. Configuration is written through i_cfg_valid / o_cfg_ready with a
//   register index and data; o_cfg_ready is always high. Write registers
//   only while no pixels are in flight.
//   Throughput: one pixel per cycle while i_out_stall does not hold the
//   output word. The pipeline is two restoring dividers of F one-bit
//   stages each, plus the entry, multiply, add and output stages.
//   The whole pipeline advances together; when the output word is held by
//   i_out_stall, o_in_stall rises and every stage holds its contents, so no
//   word is lost or repeated.
//   Reset (synchronous, active low) clears all valid bits and returns the
//   registers to clip 0, balance one half, color mode.
module midtone_transfer_stretch_unit
    import mts_pkg::*;
#(
    parameter int SAMPLE_FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [SAMPLE_FRAC_BITS:0] i_red_in,
    input  logic [SAMPLE_FRAC_BITS:0] i_green_in,
    input  logic [SAMPLE_FRAC_BITS:0] i_blue_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [SAMPLE_FRAC_BITS:0] o_red_out,
    output logic [SAMPLE_FRAC_BITS:0] o_green_out,
    output logic [SAMPLE_FRAC_BITS:0] o_blue_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  t_cfg_idx                  i_cfg_index,
    input  logic [SAMPLE_FRAC_BITS:0] i_cfg_data
);

    localparam int         F   = SAMPLE_FRAC_BITS;
    localparam int         LAT = 2*F + 4;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic         mono;
    logic [F:0]   clip_r, clip_g, clip_b;
    logic [F-1:0] bal_r, bal_g, bal_b;
    logic [F:0]   y_r, y_g, y_b;
    logic         en;

    assign o_cfg_ready = 1'b1;

    mts_cfg #(.F(F)) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (i_cfg_valid),
        .i_index      (i_cfg_index),
        .i_data       (i_cfg_data),
        .o_mono       (mono),
        .o_clip_red   (clip_r),
        .o_clip_green (clip_g),
        .o_clip_blue  (clip_b),
        .o_bal_red    (bal_r),
        .o_bal_green  (bal_g),
        .o_bal_blue   (bal_b)
    );

    // pipeline moves unless the output word is held
    logic [LAT-1:0] r_vld;
    assign en          = !r_vld[LAT-1] || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    mts_chan #(.F(F)) u_red (
        .i_clk (i_clk), .i_en (en), .i_p (i_red_in),
        .i_clip (clip_r), .i_bal (bal_r), .o_y (y_r)
    );
    mts_chan #(.F(F)) u_green (
        .i_clk (i_clk), .i_en (en), .i_p (i_green_in),
        .i_clip (clip_g), .i_bal (bal_g), .o_y (y_g)
    );
    mts_chan #(.F(F)) u_blue (
        .i_clk (i_clk), .i_en (en), .i_p (i_blue_in),
        .i_clip (clip_b), .i_bal (bal_b), .o_y (y_b)
    );

    // monochrome mode blanks green and blue
    assign o_red_out   = y_r;
    assign o_green_out = mono ? '0 : y_g;
    assign o_blue_out  = mono ? '0 : y_b;

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_red_out <= ONE && o_green_out <= ONE && o_blue_out <= ONE))
        else $error("stretched sample above one");

    a_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && mono) |-> (o_green_out == '0 && o_blue_out == '0))
        else $error("green or blue nonzero in monochrome mode");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output stage");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

endmodule

[test/tb_midtone_transfer_stretch_unit.sv]
// Self-checking testbench for midtone_transfer_stretch_unit: directed table, then random pixels.
// Depends on mts_pkg and the unit RTL; it holds its own fixed-point stretch predictor.
module tb_midtone_transfer_stretch_unit
    import mts_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FB        = 16;
    localparam longint ONE    = 64'd1 << FB;
    localparam int  CYCLE_CAP = 600000;
    localparam t_cfg_idx CFG_SPARE = 3'd7;   // unmapped index, write must be dropped

    typedef logic [FB:0] t_smp;
    typedef struct packed {
        t_smp r;
        t_smp g;
        t_smp b;
    } t_pix;
    typedef struct {
        t_pix px;
        bit   typed;
        t_pix want;
    } t_row;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_in_valid = 1'b0, i_out_stall = 1'b0, i_cfg_valid = 1'b0;
    t_smp i_red_in = '0, i_green_in = '0, i_blue_in = '0, i_cfg_data = '0;
    t_cfg_idx i_cfg_index = CFG_MONO;
    logic o_in_stall, o_out_valid, o_cfg_ready;
    t_smp o_red_out, o_green_out, o_blue_out;

    midtone_transfer_stretch_unit #(.SAMPLE_FRAC_BITS(FB)) uut (.*);

    // Shadow copy of the register file
    bit   mono_q;
    t_smp clip_q [3];
    logic [FB-1:0] bal_q [3];

    t_pix stretched_q [$];
    int   err_cnt, words_in, words_out, cycles, src_max, sink_max;
    bit   held;

    initial forever #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Timeout after %0d cycles, %0d words pending", cycles, stretched_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Per-channel clip, rescale, midtone map
    function automatic t_smp stretch_chan(t_smp p, t_smp c, logic [FB-1:0] b);
        longint unsigned x, n, d, y;
        if (c >= ONE || p <= c) return '0;
        x = ((longint'(p) - c) << FB) / (ONE - c);
        if (x == 0) return '0;
        if (x >= ONE) return t_smp'(ONE);
        n = (ONE - b) * x;
        d = n + b * (ONE - x);
        y = (n << FB) / d;
        return (y > ONE) ? t_smp'(ONE) : t_smp'(y);
    endfunction

    function automatic t_pix stretch_pix(t_pix px);
        t_pix o;
        o.r = stretch_chan(px.r, clip_q[0], bal_q[0]);
        o.g = mono_q ? '0 : stretch_chan(px.g, clip_q[1], bal_q[1]);
        o.b = mono_q ? '0 : stretch_chan(px.b, clip_q[2], bal_q[2]);
        return o;
    endfunction

    task automatic report_mismatch(string what, t_smp got, t_smp want);
        err_cnt++;
        $display("MISMATCH word %0d %s: got %0d expected %0d", words_out, what, got, want);
    endtask

    // Output check
    always @(posedge i_clk) begin
        t_pix w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (stretched_q.size() == 0) begin
                err_cnt++;
                $display("MISMATCH unexpected output word %0d", words_out);
            end else begin
                w = stretched_q.pop_front();
                if (o_red_out !== w.r)   report_mismatch("red", o_red_out, w.r);
                if (o_green_out !== w.g) report_mismatch("green", o_green_out, w.g);
                if (o_blue_out !== w.b)  report_mismatch("blue", o_blue_out, w.b);
            end
            words_out++;
        end
    end

    // Sink: random stall per word, plus one long hold-off to back the pipe up
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = $urandom_range(0, sink_max);
            if (!held && words_out >= 200) begin
                held = 1;
                n = 400;
            end
            if (n > 0) begin
                @(negedge i_clk) i_out_stall = 1'b1;
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk) i_out_stall = 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic cfg_write(t_cfg_idx idx, t_smp val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MONO:     mono_q    = val[0];
            CFG_CLIP_RED: clip_q[0] = val;
            CFG_CLIP_GRN: clip_q[1] = val;
            CFG_CLIP_BLU: clip_q[2] = val;
            CFG_BAL_RED:  bal_q[0]  = val[FB-1:0];
            CFG_BAL_GRN:  bal_q[1]  = val[FB-1:0];
            CFG_BAL_BLU:  bal_q[2]  = val[FB-1:0];
            default: ;
        endcase
        @(negedge i_clk) i_cfg_valid = 1'b0;
    endtask

    task automatic send_pixel(t_pix px, bit typed, t_pix want);
        int n;
        n = $urandom_range(0, src_max);
        if (n > 0) begin
            @(negedge i_clk) i_in_valid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        {i_red_in, i_green_in, i_blue_in} = px;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        stretched_q.insert(stretched_q.size(), typed ? want : stretch_pix(px));
        words_in++;
    endtask

    task automatic drain;
        @(negedge i_clk) i_in_valid = 1'b0;
        while (stretched_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_smp rand_sample(t_smp c);
        case ($urandom_range(0, 7))
            0:       return t_smp'($urandom);
            1:       return t_smp'(c + $urandom_range(0, 3) - 1);
            2:       return t_smp'(ONE - $urandom_range(0, 2));
            default: return t_smp'($urandom_range(0, ONE));
        endcase
    endfunction

    function automatic t_smp rand_clip();
        case ($urandom_range(0, 9))
            0:       return t_smp'($urandom);
            1:       return t_smp'(ONE - $urandom_range(0, 1));
            2:       return '0;
            default: return t_smp'($urandom_range(0, 45000));
        endcase
    endfunction

    function automatic t_smp rand_bal();
        case ($urandom_range(0, 9))
            0:       return t_smp'($urandom);           // upper bit masked off
            1:       return t_smp'(7);
            2:       return t_smp'(65529);
            3:       return '0;
            default: return t_smp'($urandom_range(7, 65529));
        endcase
    endfunction

    initial begin
        t_row rows [$];
        t_pix px;
        int n_rand;
        mono_q = 0;
        clip_q = '{default: '0};
        bal_q  = '{default: 16'd32768};
        src_max  = 11;
        sink_max = 11;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // Reset state: identity map, so each sample comes back, saturated at one
        rows = '{
            '{'{17'd0, 17'd0, 17'd0},             1, '{17'd0, 17'd0, 17'd0}},
            '{'{17'd65536, 17'd65536, 17'd65536}, 1, '{17'd65536, 17'd65536, 17'd65536}},
            '{'{17'd131071, 17'd65537, 17'd98304}, 1, '{17'd65536, 17'd65536, 17'd65536}},
            '{'{17'd1, 17'd2, 17'd4},             1, '{17'd1, 17'd2, 17'd4}},
            '{'{17'd32768, 17'd12345, 17'd65535}, 1, '{17'd32768, 17'd12345, 17'd65535}},
            '{'{17'd43690, 17'd21845, 17'd255},   0, '{17'd0, 17'd0, 17'd0}},
            '{'{17'd7, 17'd100, 17'd50000},       0, '{17'd0, 17'd0, 17'd0}},
            '{'{17'd1, 17'd1, 17'd1},             0, '{17'd0, 17'd0, 17'd0}}
        };
        foreach (rows[i]) send_pixel(rows[i].px, rows[i].typed, rows[i].want);
        drain();

        // Mono, red clip mid-range, extreme balances, stray index
        cfg_write(CFG_MONO, 17'd1);
        cfg_write(CFG_CLIP_RED, 17'd30000);
        cfg_write(CFG_BAL_RED, 17'd7);
        cfg_write(CFG_BAL_GRN, 17'd65529);
        cfg_write(CFG_SPARE, 17'h1ffff);
        rows = '{
            '{'{17'd29999, 17'd5, 17'd5},         0, '{17'd0, 17'd0, 17'd0}},
            '{'{17'd30000, 17'd65536, 17'd65536}, 0, '{17'd0, 17'd0, 17'd0}},
            '{'{17'd30001, 17'd1, 17'd1},         0, '{17'd0, 17'd0, 17'd0}},
            '{'{17'd65535, 17'd1, 17'd1},         0, '{17'd0, 17'd0, 17'd0}},
            '{'{17'd131071, 17'd131071, 17'd0},   0, '{17'd0, 17'd0, 17'd0}}
        };
        foreach (rows[i]) send_pixel(rows[i].px, 0, rows[i].want);
        drain();

        // Clip at and above one, balance zero through a masked write
        cfg_write(CFG_MONO, 17'd0);
        cfg_write(CFG_CLIP_RED, 17'd65536);
        cfg_write(CFG_CLIP_GRN, 17'h1ffff);
        cfg_write(CFG_CLIP_BLU, 17'd0);
        cfg_write(CFG_BAL_BLU, 17'h10000);
        rows = '{
            '{'{17'd65536, 17'd131071, 17'd1},    0, '{17'd0, 17'd0, 17'd0}},
            '{'{17'd131071, 17'd65536, 17'd0},    0, '{17'd0, 17'd0, 17'd0}},
            '{'{17'd100, 17'd100, 17'd65535},     0, '{17'd0, 17'd0, 17'd0}},
            '{'{17'd70000, 17'd0, 17'd20000},     0, '{17'd0, 17'd0, 17'd0}}
        };
        foreach (rows[i]) send_pixel(rows[i].px, 0, rows[i].want);
        drain();

        // Random phases with fresh register settings and idling profiles
        n_rand = 0;
        for (int ph = 0; n_rand < 1150; ph++) begin
            cfg_write(CFG_MONO, t_smp'($urandom_range(0, 3) == 0));
            cfg_write(CFG_CLIP_RED, rand_clip());
            cfg_write(CFG_CLIP_GRN, rand_clip());
            cfg_write(CFG_CLIP_BLU, rand_clip());
            cfg_write(CFG_BAL_RED, rand_bal());
            cfg_write(CFG_BAL_GRN, rand_bal());
            cfg_write(CFG_BAL_BLU, rand_bal());
            src_max  = (ph % 3 == 1) ? 0 : 11;
            sink_max = (ph % 4 == 2) ? 0 : 11;
            repeat (128) begin
                px.r = rand_sample(clip_q[0]);
                px.g = rand_sample(clip_q[1]);
                px.b = rand_sample(clip_q[2]);
                send_pixel(px, 0, px);
                n_rand++;
            end
            drain();
        end

        $display("Covered %0d pixels (%0d returned) over many register settings,", words_in,
                 words_out);
        $display("with random idling on both sides and one long output hold-off.");
        if (err_cnt == 0 && stretched_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
